FILE: rtl/cbtba_pkg.sv
// ----------------------------------------------------------------------------
// cbtba_pkg
// Shared types, constants and widths for the CAN byte time-bucket averager.
// ----------------------------------------------------------------------------
package cbtba_pkg;

  localparam int NUM_IDS_DEF       = 16;
  localparam int FRAMES_PER_ID_DEF = 64;
  localparam int MAX_BUCKETS_DEF   = 64;

  localparam int TS_W   = 48;
  localparam int ID_W   = 29;
  localparam int BYTE_N = 8;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MAX_FRAMES = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_BUCKETS    = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ADD_WR,
    ST_Q_DIV,
    ST_Q_ZERO,
    ST_Q_RD,
    ST_Q_FRAME,
    ST_Q_ACC,
    ST_Q_EMIT_RD,
    ST_Q_EMIT_DIV,
    ST_Q_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [28:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [47:0] timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  bucket_index;
    logic        has_data;
    logic [6:0]  frame_count;
    logic        last;
    logic [15:0] avg_byte_0;
    logic [15:0] avg_byte_1;
    logic [15:0] avg_byte_2;
    logic [15:0] avg_byte_3;
    logic [15:0] avg_byte_4;
    logic [15:0] avg_byte_5;
    logic [15:0] avg_byte_6;
    logic [15:0] avg_byte_7;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

endpackage

FILE: rtl/cbtba_ram.sv
// ----------------------------------------------------------------------------
// cbtba_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cbtba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cbtba_div.sv
// ----------------------------------------------------------------------------
// cbtba_div
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module cbtba_div
  import cbtba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic [63:0] quo
);

  logic [63:0] num;
  logic [47:0] den;
  logic [48:0] rem;
  logic [6:0]  cnt;
  logic [48:0] trial;
  logic [48:0] shifted;

  assign shifted = {rem[47:0], num[63]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      if (!trial[48]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/can_byte_time_bucket_averager_unit.sv
// ----------------------------------------------------------------------------
// can_byte_time_bucket_averager_unit
// Per-identifier frame rings in RAM with time-bucketed byte averages.
// ----------------------------------------------------------------------------
// Add looks up or allocates the ID, then writes the frame. Query: a width division,
// a clear of every bucket's sums, a read of each stored frame plus a division for each
// frame in the window, then one row per bucket, with 8 byte divisions for each row with
// data, each row held until taken. All divisions share the one divider.
// Synchronous reset clears the ID valid bits, ring pointers and latest time.
module can_byte_time_bucket_averager_unit
  import cbtba_pkg::*;
#(
  parameter int NUM_IDS       = NUM_IDS_DEF,
  parameter int FRAMES_PER_ID = FRAMES_PER_ID_DEF,
  parameter int MAX_BUCKETS   = MAX_BUCKETS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int FW = (FRAMES_PER_ID > 1) ? $clog2(FRAMES_PER_ID) : 1;
  localparam int FW1 = FW + 1;
  localparam int FILL_W = $clog2(FRAMES_PER_ID + 1);
  localparam int CW = (FILL_W > 7) ? FILL_W : 7;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int MD = NUM_IDS * FRAMES_PER_ID;
  localparam int MW = $clog2(MD > 1 ? MD : 2);
  localparam int SUM_W = 8 + $clog2(FRAMES_PER_ID + 1);
  localparam int CNT_W = $clog2(FRAMES_PER_ID + 1);
  localparam int BK_W = CNT_W + 8 * SUM_W;

  logic [6:0]  max_frames;
  logic [47:0] window;
  logic [6:0]  bucket_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames <= 7'd64;
      window     <= 48'd1000000;
      bucket_cnt <= 7'd32;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_FRAMES: max_frames <= cfg_data[6:0];
        REG_WINDOW:     window     <= cfg_data;
        REG_BUCKETS:    bucket_cnt <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [ID_W-1:0]   id_tags  [NUM_IDS];
  logic [NUM_IDS-1:0] id_valid;
  logic [FW-1:0]     ring_head [NUM_IDS];
  logic [FILL_W-1:0] ring_fill [NUM_IDS];
  logic [TS_W-1:0]   latest;

  state_t state, state_next;
  in_word_t cur;
  logic            hit;
  logic [IW-1:0]   ent;
  logic            found;
  logic            free_ok;
  logic [IW-1:0]   free_e;

  always_comb begin
    found = 1'b0;
    ent = '0;
    free_ok = 1'b0;
    free_e = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (id_valid[i] && id_tags[i] == cur.can_id) begin
        found = 1'b1;
        ent = IW'(i);
      end
      if (!id_valid[i]) begin
        free_ok = 1'b1;
        free_e = IW'(i);
      end
    end
  end

  logic [IW-1:0]     e;
  logic [FILL_W-1:0] fill;
  logic [FW-1:0]     head;

  // frame RAM: time + bytes
  logic          f_we;
  logic [MW-1:0] f_waddr, f_raddr;
  logic [111:0]  f_wdata, f_rdata;

  cbtba_ram #(.WIDTH(112), .DEPTH(MD)) u_frames (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // bucket accumulator RAM
  logic          b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [BK_W-1:0] b_wdata, b_rdata;

  cbtba_ram #(.WIDTH(BK_W), .DEPTH(MAX_BUCKETS)) u_buckets (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  div_req_t    dreq;
  logic        dbusy;
  logic [63:0] dquo;
  logic        div_start;
  logic [63:0] div_num;
  logic [47:0] div_den;

  assign dreq = {div_start, div_num, div_den};

  cbtba_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quo(dquo));

  logic [6:0]  bc;
  logic [CW-1:0] cap;
  logic [47:0] vstart;
  logic [47:0] width;
  logic [CW-1:0] k;
  logic [BW-1:0] row;
  logic [63:0] fbytes;
  logic        div_wait;
  logic [BW-1:0] bidx;
  logic [3:0]  bsel;
  logic [15:0] avgs [8];
  logic        qok;

  always_comb begin
    bc = (bucket_cnt > 7'(MAX_BUCKETS)) ? 7'(MAX_BUCKETS) : bucket_cnt;
    cap = (max_frames == 7'd0) ? CW'(1) : CW'(max_frames);
    if (cap > CW'(FRAMES_PER_ID)) cap = CW'(FRAMES_PER_ID);
  end

  logic [63:0] masked;
  always_comb begin
    masked = cur.payload;
    if (cur.dlc < 4'd8) begin
      masked = cur.payload & ((64'd1 << {cur.dlc[2:0], 3'b000}) - 64'd1);
    end
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  logic [FILL_W-1:0] nf;
  logic [FW-1:0] nh;
  logic [CW-1:0] trim;
  logic [FW1-1:0] nh_sum, wpos_sum, rpos_sum;
  logic [FW-1:0] wpos, rpos;

  always_comb begin
    trim = (CW'(fill) >= cap) ? (CW'(fill) - cap + CW'(1)) : '0;
    nh_sum = FW1'(head) + FW1'(trim);
    nh = (nh_sum >= FW1'(FRAMES_PER_ID)) ? FW'(nh_sum - FW1'(FRAMES_PER_ID)) : FW'(nh_sum);
    nf = FILL_W'(CW'(fill) - trim);
    wpos_sum = FW1'(nh) + FW1'(nf);
    wpos = (wpos_sum >= FW1'(FRAMES_PER_ID)) ?
           FW'(wpos_sum - FW1'(FRAMES_PER_ID)) : FW'(wpos_sum);
    rpos_sum = FW1'(head) + FW1'(k);
    rpos = (rpos_sum >= FW1'(FRAMES_PER_ID)) ?
           FW'(rpos_sum - FW1'(FRAMES_PER_ID)) : FW'(rpos_sum);
  end

  logic frame_skip;
  logic row_last;
  logic bk_empty;
  logic q_done;
  logic start_next;
  logic f_we_next;
  logic b_we_next;

  assign frame_skip = (f_rdata[111:64] < vstart) || (f_rdata[111:64] > latest);
  assign row_last   = (7'(row) == bc - 7'd1);
  assign bk_empty   = (b_rdata[BK_W-1 -: CNT_W] == '0);
  assign q_done     = !qok || (k >= CW'(fill));

  always_comb begin
    state_next = state;
    start_next = 1'b0;
    f_we_next  = 1'b0;
    b_we_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        unique case (cmd_t'(cur.cmd))
          CMD_ADD: state_next = (found || free_ok) ? ST_ADD_WR : ST_IDLE;
          CMD_QUERY: begin
            if (bc == 7'd0) begin
              state_next = ST_IDLE;
            end else begin
              state_next = ST_Q_DIV;
              start_next = 1'b1;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ADD_WR: begin
        f_we_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q_DIV: begin
        if (!div_wait && !dbusy) state_next = ST_Q_ZERO;
      end
      ST_Q_ZERO: begin
        b_we_next = 1'b1;
        if (row_last) state_next = ST_Q_RD;
      end
      ST_Q_RD: begin
        state_next = q_done ? ST_Q_EMIT_RD : ST_Q_FRAME;
      end
      ST_Q_FRAME: begin
        if (!div_wait) begin
          if (frame_skip) begin
            state_next = ST_Q_RD;
          end else begin
            state_next = ST_Q_ACC;
            start_next = 1'b1;
          end
        end
      end
      ST_Q_ACC: begin
        if (!div_wait && bsel == 4'd2) begin
          b_we_next  = 1'b1;
          state_next = ST_Q_RD;
        end
      end
      ST_Q_EMIT_RD: begin
        if (!out_valid) state_next = ST_Q_EMIT_DIV;
      end
      ST_Q_EMIT_DIV: begin
        if (!div_wait && !dbusy) begin
          if (!qok || bk_empty || bsel == 4'd8) begin
            state_next = ST_Q_EMIT_OUT;
          end else begin
            start_next = 1'b1;
          end
        end
      end
      ST_Q_EMIT_OUT: begin
        state_next = row_last ? ST_IDLE : ST_Q_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      f_we      <= 1'b0;
      b_we      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      f_we      <= f_we_next;
      b_we      <= b_we_next;
      div_start <= start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_valid <= '0;
      latest <= '0;
      out_valid <= 1'b0;
      div_wait <= 1'b0;
      for (int i = 0; i < NUM_IDS; i++) begin
        ring_head[i] <= '0;
        ring_fill[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_data;
          end
        end
        ST_LOOKUP: begin
          unique case (cmd_t'(cur.cmd))
            CMD_ADD: begin
              if (cur.timestamp_us > latest) latest <= cur.timestamp_us;
              if (found) begin
                e <= ent; fill <= ring_fill[ent]; head <= ring_head[ent];
              end else if (free_ok) begin
                e <= free_e; fill <= '0; head <= '0;
                id_valid[free_e] <= 1'b1;
                id_tags[free_e] <= cur.can_id;
              end
            end
            CMD_CLEAR: begin
              id_valid <= '0;
              latest <= '0;
              for (int i = 0; i < NUM_IDS; i++) begin
                ring_head[i] <= '0;
                ring_fill[i] <= '0;
              end
            end
            CMD_QUERY: begin
              if (bc != 7'd0) begin
                e <= ent;
                qok <= found && (window != 48'd0);
                fill <= found ? ring_fill[ent] : '0;
                head <= ring_head[ent];
                vstart <= (latest > window) ? latest - window : 48'd0;
                div_num <= {16'd0, window};
                div_den <= {41'd0, bc};
                div_wait <= 1'b1;
                row <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_ADD_WR: begin
          f_waddr <= MW'(32'(e) * FRAMES_PER_ID + 32'(wpos));
          f_wdata <= {cur.timestamp_us, masked};
          ring_head[e] <= nh;
          ring_fill[e] <= nf + FILL_W'(1);
        end
        ST_Q_DIV: begin
          if (div_wait) begin
            div_wait <= 1'b0;
          end else if (!dbusy) begin
            width <= (dquo[47:0] == 48'd0) ? 48'd1 : dquo[47:0];
          end
        end
        ST_Q_ZERO: begin
          b_waddr <= row;
          b_wdata <= '0;
          if (row_last) begin
            k <= '0;
          end else begin
            row <= row + BW'(1);
          end
        end
        ST_Q_RD: begin
          if (q_done) begin
            row <= '0;
            b_raddr <= '0;
          end else begin
            f_raddr <= MW'(32'(e) * FRAMES_PER_ID + 32'(rpos));
            div_wait <= 1'b1;
          end
        end
        ST_Q_FRAME: begin
          if (div_wait) begin
            div_wait <= 1'b0;
          end else begin
            fbytes <= f_rdata[63:0];
            if (frame_skip) begin
              k <= k + CW'(1);
            end else begin
              div_num <= {16'd0, f_rdata[111:64] - vstart};
              div_den <= width;
              div_wait <= 1'b1;
              bsel <= 4'd0;
            end
          end
        end
        ST_Q_ACC: begin
          if (div_wait) begin
            div_wait <= 1'b0;
          end else if (!dbusy && bsel == 4'd0) begin
            bidx <= (dquo > 64'(bc - 7'd1)) ? BW'(bc - 7'd1) : BW'(dquo);
            b_raddr <= (dquo > 64'(bc - 7'd1)) ? BW'(bc - 7'd1) : BW'(dquo);
            bsel <= 4'd1;
          end else if (bsel == 4'd1) begin
            bsel <= 4'd2;
          end else if (bsel == 4'd2) begin
            b_waddr <= bidx;
            for (int b = 0; b < 8; b++) begin
              b_wdata[b*SUM_W +: SUM_W] <= b_rdata[b*SUM_W +: SUM_W] +
                                           SUM_W'(fbytes[b*8 +: 8]);
            end
            b_wdata[BK_W-1 -: CNT_W] <= b_rdata[BK_W-1 -: CNT_W] + CNT_W'(1);
            k <= k + CW'(1);
          end
        end
        ST_Q_EMIT_RD: begin
          if (!out_valid) begin
            bsel <= 4'd0;
            div_wait <= 1'b0;
          end
        end
        ST_Q_EMIT_DIV: begin
          if (div_wait) begin
            div_wait <= 1'b0;
          end else if (!dbusy) begin
            if (bsel != 4'd0) avgs[3'(bsel - 4'd1)] <= dquo[15:0];
            if (!qok || bk_empty) begin
              for (int b = 0; b < 8; b++) avgs[b] <= 16'd0;
            end else if (bsel != 4'd8) begin
              div_num <= 64'({b_rdata[bsel[2:0]*SUM_W +: SUM_W], 8'd0});
              div_den <= 48'(b_rdata[BK_W-1 -: CNT_W]);
              div_wait <= 1'b1;
              bsel <= bsel + 4'd1;
            end
          end
        end
        ST_Q_EMIT_OUT: begin
          out_valid <= 1'b1;
          out_data.bucket_index <= 6'(row);
          out_data.has_data <= qok && !bk_empty;
          out_data.frame_count <= 7'(fill);
          out_data.last <= row_last;
          out_data.avg_byte_0 <= avgs[0];
          out_data.avg_byte_1 <= avgs[1];
          out_data.avg_byte_2 <= avgs[2];
          out_data.avg_byte_3 <= avgs[3];
          out_data.avg_byte_4 <= avgs[4];
          out_data.avg_byte_5 <= avgs[5];
          out_data.avg_byte_6 <= avgs[6];
          out_data.avg_byte_7 <= avgs[7];
          if (!row_last) begin
            row <= row + BW'(1);
            b_raddr <= row + BW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign hit = (state_next == ST_LOOKUP);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == ST_IDLE))
    else $error("ready outside idle");
  a_no_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOOKUP))
    else $error("accept did not start lookup");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_hit: assert property (@(posedge clk) disable iff (rst)
    hit |-> (state == ST_IDLE))
    else $error("lookup entered from busy");

endmodule
